/* rtl/uidq_pkg.sv */
// Shared types and codes for the unique-ID FIFO queue.
// No dependencies; imported by the cell and the top level.
`default_nettype none
package uidq_pkg;

	// Request codes
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_DUMP   = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DUP   = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// Width of the result identifier port
	localparam int OUT_ID_W = 16;

	// Operation broadcast to every cell of the chain
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_SHIFT  = 2'd2,
		CELL_ROTATE = 2'd3
	} cell_op_t;

	// Control state, one-hot
	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_DUMP = 2'b10
	} state_t;

endpackage
`default_nettype wire

/* rtl/uidq_cell.sv */
// One storage cell of the queue chain: holds one identifier and its valid bit.
// Depends on uidq_pkg for the cell operation type.
`default_nettype none
module uidq_cell #(
	parameter int ID_BITS = 16
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  uidq_pkg::cell_op_t     op,
	input  wire  [ID_BITS-1:0]     key,
	input  wire                    prev_valid,
	input  wire  [ID_BITS-1:0]     next_id,
	input  wire                    next_valid,
	input  wire  [ID_BITS-1:0]     head_id,
	output logic [ID_BITS-1:0]     id,
	output logic                   valid,
	output logic                   match
);
	import uidq_pkg::*;

	logic [ID_BITS-1:0] id_q;
	logic               valid_q;

	// Occupancy: fills at the first free slot, shifts toward the head on removal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (op)
				CELL_INSERT: if (!valid_q && prev_valid) valid_q <= 1'b1;
				CELL_SHIFT:  valid_q <= next_valid;
				default:     valid_q <= valid_q;
			endcase
		end
	end

	// Identifier: rotation wraps the head entry into the last occupied cell
	always_ff @(posedge clk) begin
		case (op)
			CELL_INSERT: if (!valid_q && prev_valid) id_q <= key;
			CELL_SHIFT:  id_q <= next_id;
			CELL_ROTATE: if (valid_q) id_q <= next_valid ? next_id : head_id;
			default:     id_q <= id_q;
		endcase
	end

	assign id    = id_q;
	assign valid = valid_q;
	assign match = valid_q && (id_q == key);

endmodule
`default_nettype wire

/* rtl/unique_id_fifo_queue.sv */
// Top level of the unique-ID FIFO queue: control, result register, cell chain.
// Depends on uidq_pkg and uidq_cell.
//
// Usage: requests come in on req_valid/req_stall with req_type and proc_id;
// results leave on rsp_valid/rsp_stall with status, out_id and last.
// Entries live in a chain of cells, oldest in cell 0. An insert compares the
// identifier against every cell in the same cycle and appends it at the first
// free cell; a remove shifts the whole chain one cell toward the head.
// Insert and remove: the result is registered, so one request per cycle while
// the receiver keeps up. Dump: the chain rotates one cell per cycle and cell 0
// is sent each cycle while the receiver keeps up, so a dump of n entries sends
// n results and leaves the queue as it was; an empty queue gives a single
// empty status.
// Request type three is taken and produces no result.
// While a result waits under rsp_stall, or a dump is running, req_stall is
// high; nothing is dropped. Reset empties the queue and the result register
// at once, with no clearing pass.
`default_nettype none
module unique_id_fifo_queue #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 16
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           req_valid,
	output logic                          req_stall,
	input  wire  [1:0]                    req_type,
	input  wire  [15:0]                   proc_id,
	output logic                          rsp_valid,
	input  wire                           rsp_stall,
	output logic [1:0]                    status,
	output logic [uidq_pkg::OUT_ID_W-1:0] out_id,
	output logic                          last
);
	import uidq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      rem_q;
	logic               rsp_valid_q;
	logic [1:0]         status_q;
	logic [OUT_ID_W-1:0] out_id_q;
	logic               last_q;

	cell_op_t           op;
	logic [ID_BITS-1:0] key;
	logic [31:0]        key_ext;
	logic [31:0]        head_ext;
	logic [ID_BITS-1:0] cell_id    [QUEUE_DEPTH];
	logic               cell_valid [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] cell_match;

	logic accept, out_free, any_match, full, empty, rsp_load;

	// Key and head identifier width adaptation
	always_comb begin
		key_ext  = {16'b0, proc_id};
		key      = key_ext[ID_BITS-1:0];
		head_ext = '0;
		head_ext[ID_BITS-1:0] = cell_id[0];
	end

	// Cell chain
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [ID_BITS-1:0] nid;
		logic               nvalid;
		logic               pvalid;
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign nid    = '0;
			assign nvalid = 1'b0;
		end else begin : g_mid
			assign nid    = cell_id[i+1];
			assign nvalid = cell_valid[i+1];
		end
		if (i == 0) begin : g_head
			assign pvalid = 1'b1;
		end else begin : g_prev
			assign pvalid = cell_valid[i-1];
		end
		uidq_cell #(.ID_BITS(ID_BITS)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.key        (key),
			.prev_valid (pvalid),
			.next_id    (nid),
			.next_valid (nvalid),
			.head_id    (cell_id[0]),
			.id         (cell_id[i]),
			.valid      (cell_valid[i]),
			.match      (cell_match[i])
		);
	end

	// Handshake
	assign any_match = |cell_match;
	assign full      = (count_q == CW'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE) || (rsp_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;

	// A new result enters the output register
	assign rsp_load = ((state_q == S_DUMP) && out_free) ||
		((state_q == S_IDLE) && accept &&
		((req_type == REQ_INSERT) || (req_type == REQ_REMOVE) ||
		((req_type == REQ_DUMP) && empty)));

	// Cell operation decode
	always_comb begin
		op = CELL_HOLD;
		if (state_q == S_DUMP) begin
			if (out_free) op = CELL_ROTATE;
		end else if (accept) begin
			case (req_type)
				REQ_INSERT: if (!any_match && !full) op = CELL_INSERT;
				REQ_REMOVE: if (!empty) op = CELL_SHIFT;
				default:    op = CELL_HOLD;
			endcase
		end
	end

	// Control state, count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rem_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req_type)
							REQ_INSERT: begin
								if (!any_match && !full) count_q <= count_q + 1'b1;
							end
							REQ_REMOVE: begin
								if (!empty) count_q <= count_q - 1'b1;
							end
							REQ_DUMP: begin
								if (!empty) begin
									rem_q   <= count_q;
									state_q <= S_DUMP;
								end
							end
							default: ;
						endcase
					end
				end
				S_DUMP: begin
					if (out_free) begin
						rem_q <= rem_q - 1'b1;
						if (rem_q == CW'(1)) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (state_q == S_DUMP) begin
			if (out_free) begin
				status_q <= ST_OK;
				out_id_q <= head_ext[OUT_ID_W-1:0];
				last_q   <= (rem_q == CW'(1));
			end
		end else if (accept) begin
			last_q <= 1'b1;
			case (req_type)
				REQ_INSERT: begin
					status_q <= any_match ? ST_DUP : (full ? ST_FULL : ST_OK);
					out_id_q <= '0;
				end
				REQ_REMOVE: begin
					status_q <= empty ? ST_EMPTY : ST_OK;
					out_id_q <= empty ? '0 : head_ext[OUT_ID_W-1:0];
				end
				default: begin
					status_q <= ST_EMPTY;
					out_id_q <= '0;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign out_id    = out_id_q;
	assign last      = last_q;

endmodule
`default_nettype wire
